[rtl/core/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg
// Types and codes shared by the connection tracking table modules.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    OP_FIND      = 3'd0,
    OP_NAT_QUERY = 3'd1,
    OP_NAT_FAIL  = 3'd2,
    OP_NAT_OK    = 3'd3,
    OP_ADD       = 3'd4,
    OP_DEL_KEY   = 3'd5,
    OP_DEL_RULE  = 3'd6,
    OP_TICK      = 3'd7
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NFOUND = 2'd1;
  localparam logic [1:0] ST_EXISTS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // NAT state held per entry
  localparam logic [1:0] NAT_NONE     = 2'd0;
  localparam logic [1:0] NAT_FAILED   = 2'd1;
  localparam logic [1:0] NAT_SIDE_SRC = 2'd2;
  localparam logic [1:0] NAT_SIDE_DST = 2'd3;

  // NAT answers
  localparam logic [1:0] ANS_NONE  = 2'd0;
  localparam logic [1:0] ANS_REFUSE = 2'd1;
  localparam logic [1:0] ANS_XLATE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_LIFETIME = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  localparam int          ADDR_W    = 12;
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  // One stored connection
  typedef struct packed {
    logic        valid;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [31:0] handle;
    logic [1:0]  nat_state;
    logic [63:0] nat_rec;
    logic [15:0] last_use;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Row memory request
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_IDX,
    S_EXEC,
    S_TICK,
    S_WRD,
    S_WWR,
    S_FIN
  } state_t;

endpackage

[rtl/core/cct_if.sv]
// ----------------------------------------------------------------------------
// cct_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic [31:0] src_mask;
  logic [31:0] dst_mask;
  logic [15:0] src_port_high;
  logic [15:0] dst_port_high;
  logic [31:0] state_handle;
  logic [63:0] nat_data;

  modport source (output valid, operation, src_ip, dst_ip, src_port, dst_port, protocol,
                  src_mask, dst_mask, src_port_high, dst_port_high, state_handle,
                  nat_data, input ready);
  modport sink   (input valid, operation, src_ip, dst_ip, src_port, dst_port, protocol,
                  src_mask, dst_mask, src_port_high, dst_port_high, state_handle,
                  nat_data, output ready);
endinterface

interface cct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] handle_out;
  logic [1:0]  nat_answer;
  logic [63:0] nat_out;
  logic [10:0] removed_count;

  modport source (output valid, status, handle_out, nat_answer, nat_out, removed_count,
                  input ready);
  modport sink   (input valid, status, handle_out, nat_answer, nat_out, removed_count,
                  output ready);
endinterface

[rtl/core/cct_row_ram.sv]
// ----------------------------------------------------------------------------
// cct_row_ram
// One write port, one read port row memory with registered read data.
// ----------------------------------------------------------------------------
module cct_row_ram #(
  parameter int SETS = 256,
  parameter int ROW_W = 8
) (
  input  logic                clk,
  input  cct_pkg::ram_req_t   req,
  input  logic [ROW_W-1:0]    wdata,
  output logic [ROW_W-1:0]    rdata
);
  import cct_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[SET_W-1:0]] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr[SET_W-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/cct_engine.sv]
// ----------------------------------------------------------------------------
// cct_engine
// Sequencer: hashing, set read-modify-write, table walks and result register.
// ----------------------------------------------------------------------------
module cct_engine #(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cct_in_if.sink                       in_ch,
  cct_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [7:0]                   cfg_data,
  output cct_pkg::ram_req_t            ram_req,
  output logic [WAYS*cct_pkg::ENTRY_W-1:0] ram_wdata,
  input  logic [WAYS*cct_pkg::ENTRY_W-1:0] ram_rdata
);
  import cct_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [63:0] RECIP64 = ((64'd1 << 32) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [32:0] RECIP = RECIP64[32:0];
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  // ---- registers ----
  state_t            state_r, state_nxt;
  logic [SET_W-1:0]  ctr_r, ctr_nxt;
  logic              sweep_r, sweep_nxt;
  logic [10:0]       rem_r, rem_nxt;
  logic [7:0]        life_r, intv_r;
  logic [15:0]       time_r, time_nxt;
  logic [7:0]        cdwn_r, cdwn_nxt;
  logic              out_valid_r, out_valid_nxt;

  // item held while it is worked on
  logic [2:0]  op_r;
  logic [31:0] sip_r, dip_r, smask_r, dmask_r, hnd_r;
  logic [15:0] sp_r, dp_r, sph_r, dph_r;
  logic [7:0]  pr_r;
  logic [63:0] nat_r;
  logic [15:0] v_r;
  logic [15:0] q_r;

  logic [1:0]  status_r, status_nxt;
  logic [31:0] handle_r, handle_nxt;
  logic [1:0]  ans_r, ans_nxt;
  logic [63:0] nout_r, nout_nxt;
  logic [10:0] rcnt_r, rcnt_nxt;

  // ---- combinational ----
  entry_t [WAYS-1:0] row, row_new;
  logic [WAYS-1:0]   hit_v, free_v, kill_v;
  logic              hit, free_any, slot_free, load;
  logic [WAY_W-1:0]  hit_w, free_w;
  logic [31:0]       rem_prod;
  logic [SET_W-1:0]  set_idx;
  logic [15:0]       time_inc;
  logic [7:0]        cd_inc;
  logic [11:0]       rem_sum;
  logic [15:0]       hash_v;
  logic [48:0]       qprod;

  assign row       = ram_rdata;
  assign ram_wdata = row_new;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign time_inc  = time_r + 16'd1;
  assign cd_inc    = cdwn_r + 8'd1;

  // symmetric hash of the incoming tuple
  assign hash_v = {8'd0, in_ch.protocol} ^ in_ch.src_ip[15:0] ^ in_ch.src_ip[31:16]
                ^ in_ch.dst_ip[15:0] ^ in_ch.dst_ip[31:16] ^ in_ch.src_port ^ in_ch.dst_port;

  // modulo by reciprocal: quotient then remainder
  assign qprod    = 49'(v_r) * 49'(RECIP);
  assign rem_prod = 32'(v_r) - 32'(q_r) * 32'(SETS);
  assign set_idx  = rem_prod[SET_W-1:0];

  // per-way lookup, both directions
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_v[w] = row[w].valid && (row[w].protocol == pr_r) &&
                 ((row[w].src_ip == sip_r && row[w].dst_ip == dip_r &&
                   row[w].src_port == sp_r && row[w].dst_port == dp_r) ||
                  (row[w].src_ip == dip_r && row[w].dst_ip == sip_r &&
                   row[w].src_port == dp_r && row[w].dst_port == sp_r));
      free_v[w] = !row[w].valid;
    end
  end

  // lowest matching and lowest free way
  always_comb begin
    hit_w  = '0;
    free_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) hit_w = WAY_W'(w);
      if (free_v[w]) free_w = WAY_W'(w);
    end
  end

  assign hit      = |hit_v;
  assign free_any = |free_v;

  // walk removal: rule match or aged out
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (sweep_r) begin
        kill_v[w] = row[w].valid &&
                    (16'(time_r - row[w].last_use) >= {8'd0, life_r});
      end else begin
        kill_v[w] = row[w].valid &&
                    ((row[w].src_ip & smask_r) == (sip_r & smask_r)) &&
                    ((row[w].dst_ip & dmask_r) == (dip_r & dmask_r)) &&
                    (row[w].src_port >= sp_r) && (row[w].src_port <= sph_r) &&
                    (row[w].dst_port >= dp_r) && (row[w].dst_port <= dph_r) &&
                    ((pr_r == 8'd0) || (pr_r == row[w].protocol));
      end
    end
  end

  always_comb begin
    rem_sum = {1'b0, rem_r} + 12'($countones(kill_v));
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (ctr_r == LAST_SET) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_ch.valid) begin
          if (op_t'(in_ch.operation) == OP_TICK) state_nxt = S_TICK;
          else if (op_t'(in_ch.operation) == OP_DEL_RULE) state_nxt = S_WRD;
          else state_nxt = S_HASH;
        end
      end
      S_HASH: state_nxt = S_IDX;
      S_IDX:  if (slot_free) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      S_TICK: state_nxt = (cd_inc >= intv_r) ? S_WRD : S_FIN;
      S_WRD:  state_nxt = S_WWR;
      S_WWR:  state_nxt = (ctr_r == LAST_SET) ? S_FIN : S_WRD;
      S_FIN:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- outputs and datapath ----
  always_comb begin
    in_ch.ready   = (state_r == S_IDLE);
    ram_req       = '0;
    row_new       = row;
    ctr_nxt       = ctr_r;
    sweep_nxt     = sweep_r;
    rem_nxt       = rem_r;
    time_nxt      = time_r;
    cdwn_nxt      = cdwn_r;
    load          = 1'b0;
    status_nxt    = ST_OK;
    handle_nxt    = '0;
    ans_nxt       = ANS_NONE;
    nout_nxt      = '0;
    rcnt_nxt      = '0;
    case (state_r)
      S_CLEAR: begin
        row_new       = '0;
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(ctr_r);
        ctr_nxt       = ctr_r + SET_W'(1);
      end
      S_IDLE: begin
        ctr_nxt   = '0;
        rem_nxt   = '0;
        sweep_nxt = 1'b0;
      end
      S_IDX: begin
        ram_req.re    = slot_free;
        ram_req.raddr = ADDR_W'(set_idx);
        ctr_nxt       = set_idx;
      end
      S_EXEC: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(ctr_r);
        load          = 1'b1;
        if (op_t'(op_r) == OP_ADD) begin
          if (hit) begin
            status_nxt = ST_EXISTS;
          end else if (free_any) begin
            row_new[free_w].valid     = 1'b1;
            row_new[free_w].src_ip    = sip_r;
            row_new[free_w].dst_ip    = dip_r;
            row_new[free_w].src_port  = sp_r;
            row_new[free_w].dst_port  = dp_r;
            row_new[free_w].protocol  = pr_r;
            row_new[free_w].handle    = hnd_r;
            row_new[free_w].nat_state = NAT_NONE;
            row_new[free_w].nat_rec   = '0;
            row_new[free_w].last_use  = time_r;
          end else begin
            status_nxt = ST_FULL;
          end
        end else if (!hit) begin
          status_nxt = ST_NFOUND;
        end else begin
          case (op_t'(op_r))
            OP_FIND: begin
              row_new[hit_w].last_use = time_r;
              handle_nxt = row[hit_w].handle;
            end
            OP_NAT_QUERY: begin
              if (row[hit_w].nat_state == NAT_NONE) begin
                ans_nxt = ANS_NONE;
              end else if (row[hit_w].nat_state == NAT_FAILED) begin
                ans_nxt = ANS_REFUSE;
              end else if ((row[hit_w].nat_state == NAT_SIDE_SRC) ?
                           (sip_r == row[hit_w].src_ip && sp_r == row[hit_w].src_port) :
                           (sip_r == row[hit_w].dst_ip && sp_r == row[hit_w].dst_port)) begin
                ans_nxt  = ANS_XLATE;
                nout_nxt = row[hit_w].nat_rec;
              end else begin
                ans_nxt = ANS_REFUSE;
              end
            end
            OP_NAT_FAIL: row_new[hit_w].nat_state = NAT_FAILED;
            OP_NAT_OK: begin
              row_new[hit_w].nat_state =
                (sip_r == row[hit_w].src_ip && sp_r == row[hit_w].src_port) ?
                NAT_SIDE_SRC : NAT_SIDE_DST;
              row_new[hit_w].nat_rec = nat_r;
            end
            OP_DEL_KEY: begin
              row_new[hit_w].valid = 1'b0;
              rcnt_nxt = 11'd1;
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        time_nxt  = time_inc;
        cdwn_nxt  = (cd_inc >= intv_r) ? 8'd0 : cd_inc;
        sweep_nxt = 1'b1;
      end
      S_WRD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ADDR_W'(ctr_r);
      end
      S_WWR: begin
        for (int w = 0; w < WAYS; w++) begin
          if (kill_v[w]) row_new[w].valid = 1'b0;
        end
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(ctr_r);
        rem_nxt       = rem_sum[11] ? COUNT_MAX : rem_sum[10:0];
        ctr_nxt       = ctr_r + SET_W'(1);
      end
      S_FIN: begin
        load     = slot_free;
        rcnt_nxt = rem_r;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ctr_r       <= '0;
      sweep_r     <= 1'b0;
      rem_r       <= '0;
      time_r      <= '0;
      cdwn_r      <= '0;
      out_valid_r <= 1'b0;
      life_r      <= 8'd7;
      intv_r      <= 8'd5;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      sweep_r     <= sweep_nxt;
      rem_r       <= rem_nxt;
      time_r      <= time_nxt;
      cdwn_r      <= cdwn_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIFETIME: life_r <= cfg_data;
          CFG_INTERVAL: intv_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r    <= in_ch.operation;
      sip_r   <= in_ch.src_ip;
      dip_r   <= in_ch.dst_ip;
      sp_r    <= in_ch.src_port;
      dp_r    <= in_ch.dst_port;
      pr_r    <= in_ch.protocol;
      smask_r <= in_ch.src_mask;
      dmask_r <= in_ch.dst_mask;
      sph_r   <= in_ch.src_port_high;
      dph_r   <= in_ch.dst_port_high;
      hnd_r   <= in_ch.state_handle;
      nat_r   <= in_ch.nat_data;
      v_r     <= hash_v;
    end
    if (state_r == S_HASH) q_r <= qprod[47:32];
    if (load) begin
      status_r <= status_nxt;
      handle_r <= handle_nxt;
      ans_r    <= ans_nxt;
      nout_r   <= nout_nxt;
      rcnt_r   <= rcnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.handle_out    = handle_r;
  assign out_ch.nat_answer    = ans_r;
  assign out_ch.nat_out       = nout_r;
  assign out_ch.removed_count = rcnt_r;

  // ---- assertions ----
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid_r)
    else $error("set operation finished without a result");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_req.we)
    else $error("row write while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("item accepted but sequencer stayed idle");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !out_valid_r)
    else $error("result register overwritten");

endmodule

[rtl/core/connection_tracking_table.sv]
// ----------------------------------------------------------------------------
// connection_tracking_table
// Direction-blind 5-tuple connection table with NAT records and ageing.
// ----------------------------------------------------------------------------
// After reset the block clears every row of its row memory and takes no item
// meanwhile. Keyed operations (find, NAT query/set, add, delete key) run
// through capture with hash, quotient, remainder and row read, then a single
// read-modify-write of the set's row that also registers the result. Rule
// deletes walk every row through the one memory port pair, a row read and
// then a row write per row; a tick that sweeps walks the rows the same way,
// and a tick that does not sweep goes straight to its final step. The row
// read of a keyed operation and the final step of a walk or tick wait while
// an earlier result still sits unaccepted. One item is worked on at a time;
// the next can be taken while the previous result still waits in the output
// register.
module connection_tracking_table #(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  cct_in_if.sink     in_ch,
  cct_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import cct_pkg::*;

  localparam int ROW_W = WAYS * ENTRY_W;

  ram_req_t         ram_req;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  // set memory, one row of WAYS entries per set
  cct_row_ram #(.SETS(SETS), .ROW_W(ROW_W)) u_ram (
    .clk   (clk),
    .req   (ram_req),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer and datapath
  cct_engine #(.SETS(SETS), .WAYS(WAYS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the connection tracking table. Each accepted item
// goes through an in-bench model of the table, and the expected result is
// queued. A separate process compares every result against the queue.
// Directed tests cover each operation, direction-blind matching, full sets,
// rule deletes and ageing. Random phases then run with different idling and
// register settings.
// ----------------------------------------------------------------------------
module testbench;
  import cct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS    = 256;
  localparam int NWAYS    = 4;
  localparam int NENTRIES = NSETS * NWAYS;
  localparam int DRAIN_CYCLES = 2 * NSETS + 64;

  typedef struct {
    op_t         op;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  pr;
    logic [31:0] smask;
    logic [31:0] dmask;
    logic [15:0] sph;
    logic [15:0] dph;
    logic [31:0] hnd;
    logic [63:0] nat;
  } conn_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] handle;
    logic [1:0]  answer;
    logic [63:0] nat;
    logic [10:0] removed;
  } conn_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_data;

  cct_in_if  in_ch ();
  cct_out_if out_ch ();

  connection_tracking_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model of the table
  logic        tbl_valid [NENTRIES];
  logic [31:0] tbl_sip   [NENTRIES];
  logic [31:0] tbl_dip   [NENTRIES];
  logic [15:0] tbl_sp    [NENTRIES];
  logic [15:0] tbl_dp    [NENTRIES];
  logic [7:0]  tbl_pr    [NENTRIES];
  logic [31:0] tbl_hnd   [NENTRIES];
  logic [1:0]  tbl_nat_st[NENTRIES];
  logic [63:0] tbl_rec   [NENTRIES];
  logic [15:0] tbl_used  [NENTRIES];
  logic [15:0] now_secs;
  logic [7:0]  sweep_cnt;
  logic [7:0]  lifetime;
  logic [7:0]  interval;

  conn_res_t pending_q[$];
  conn_req_t known_q[$];
  int errors;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_cycles;
  int hot_set[4];

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int set_index(logic [31:0] sip, logic [31:0] dip,
                                   logic [15:0] sp, logic [15:0] dp, logic [7:0] pr);
    logic [15:0] v;
    v = {8'h00, pr} ^ sip[15:0] ^ sip[31:16] ^ dip[15:0] ^ dip[31:16] ^ sp ^ dp;
    return int'(v) % NSETS;
  endfunction

  // Index of the entry holding the tuple in either direction, or -1
  function automatic int find_entry(conn_req_t r);
    int base;
    int i;
    base = set_index(r.sip, r.dip, r.sp, r.dp, r.pr) * NWAYS;
    for (int w = 0; w < NWAYS; w++) begin
      i = base + w;
      if (tbl_valid[i] && tbl_pr[i] == r.pr) begin
        if (tbl_sip[i] == r.sip && tbl_dip[i] == r.dip && tbl_sp[i] == r.sp &&
            tbl_dp[i] == r.dp) return i;
        if (tbl_sip[i] == r.dip && tbl_dip[i] == r.sip && tbl_sp[i] == r.dp &&
            tbl_dp[i] == r.sp) return i;
      end
    end
    return -1;
  endfunction

  function automatic logic [10:0] count_up(logic [10:0] c);
    return (c < COUNT_MAX) ? c + 11'd1 : c;
  endfunction

  // Works out the result of one item and updates the model
  function automatic conn_res_t table_response(conn_req_t r);
    conn_res_t   res;
    int          i;
    int          base;
    logic [15:0] age;
    logic [31:0] side_ip;
    logic [15:0] side_port;
    res = '{ST_OK, 32'd0, ANS_NONE, 64'd0, 11'd0};
    case (r.op)
      OP_FIND, OP_NAT_QUERY, OP_NAT_FAIL, OP_NAT_OK, OP_DEL_KEY: begin
        i = find_entry(r);
        if (i < 0) begin
          res.status = ST_NFOUND;
        end else begin
          case (r.op)
            OP_FIND: begin
              tbl_used[i] = now_secs;
              res.handle  = tbl_hnd[i];
            end
            OP_NAT_QUERY: begin
              if (tbl_nat_st[i] == NAT_NONE) begin
                res.answer = ANS_NONE;
              end else if (tbl_nat_st[i] == NAT_FAILED) begin
                res.answer = ANS_REFUSE;
              end else begin
                side_ip   = (tbl_nat_st[i] == NAT_SIDE_SRC) ? tbl_sip[i] : tbl_dip[i];
                side_port = (tbl_nat_st[i] == NAT_SIDE_SRC) ? tbl_sp[i] : tbl_dp[i];
                if (r.sip == side_ip && r.sp == side_port) begin
                  res.answer = ANS_XLATE;
                  res.nat    = tbl_rec[i];
                end else begin
                  res.answer = ANS_REFUSE;
                end
              end
            end
            OP_NAT_FAIL: tbl_nat_st[i] = NAT_FAILED;
            OP_NAT_OK: begin
              tbl_nat_st[i] = (r.sip == tbl_sip[i] && r.sp == tbl_sp[i]) ?
                              NAT_SIDE_SRC : NAT_SIDE_DST;
              tbl_rec[i] = r.nat;
            end
            default: begin
              tbl_valid[i] = 1'b0;
              res.removed  = 11'd1;
            end
          endcase
        end
      end
      OP_ADD: begin
        if (find_entry(r) >= 0) begin
          res.status = ST_EXISTS;
        end else begin
          base = set_index(r.sip, r.dip, r.sp, r.dp, r.pr) * NWAYS;
          res.status = ST_FULL;
          for (int w = 0; w < NWAYS; w++) begin
            i = base + w;
            if (res.status == ST_FULL && !tbl_valid[i]) begin
              tbl_valid[i]  = 1'b1;
              tbl_sip[i]    = r.sip;
              tbl_dip[i]    = r.dip;
              tbl_sp[i]     = r.sp;
              tbl_dp[i]     = r.dp;
              tbl_pr[i]     = r.pr;
              tbl_hnd[i]    = r.hnd;
              tbl_nat_st[i] = NAT_NONE;
              tbl_rec[i]    = 64'd0;
              tbl_used[i]   = now_secs;
              res.status    = ST_OK;
            end
          end
        end
      end
      OP_DEL_RULE: begin
        for (int k = 0; k < NENTRIES; k++) begin
          if (tbl_valid[k] &&
              (tbl_sip[k] & r.smask) == (r.sip & r.smask) &&
              (tbl_dip[k] & r.dmask) == (r.dip & r.dmask) &&
              tbl_sp[k] >= r.sp && tbl_sp[k] <= r.sph &&
              tbl_dp[k] >= r.dp && tbl_dp[k] <= r.dph &&
              (r.pr == 8'd0 || r.pr == tbl_pr[k])) begin
            tbl_valid[k] = 1'b0;
            res.removed  = count_up(res.removed);
          end
        end
      end
      default: begin
        now_secs  = now_secs + 16'd1;
        sweep_cnt = sweep_cnt + 8'd1;
        if (sweep_cnt >= interval) begin
          sweep_cnt = 8'd0;
          for (int k = 0; k < NENTRIES; k++) begin
            age = now_secs - tbl_used[k];
            if (tbl_valid[k] && age >= {8'd0, lifetime}) begin
              tbl_valid[k] = 1'b0;
              res.removed  = count_up(res.removed);
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Result side: checks accepted results, drives ready
  initial begin
    conn_res_t e;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = pending_q.pop_front();
          if (out_ch.status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", out_ch.status, e.status));
          if (out_ch.handle_out !== e.handle)
            report_mismatch($sformatf("handle %h, want %h", out_ch.handle_out, e.handle));
          if (out_ch.nat_answer !== e.answer)
            report_mismatch($sformatf("nat answer %0d, want %0d", out_ch.nat_answer,
                                      e.answer));
          if (out_ch.nat_out !== e.nat)
            report_mismatch($sformatf("nat record %h, want %h", out_ch.nat_out, e.nat));
          if (out_ch.removed_count !== e.removed)
            report_mismatch($sformatf("removed %0d, want %0d", out_ch.removed_count,
                                      e.removed));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offers one item and waits until it is taken
  task automatic send_item(conn_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= r.op;
    in_ch.src_ip        <= r.sip;
    in_ch.dst_ip        <= r.dip;
    in_ch.src_port      <= r.sp;
    in_ch.dst_port      <= r.dp;
    in_ch.protocol      <= r.pr;
    in_ch.src_mask      <= r.smask;
    in_ch.dst_mask      <= r.dmask;
    in_ch.src_port_high <= r.sph;
    in_ch.dst_port_high <= r.dph;
    in_ch.state_handle  <= r.hnd;
    in_ch.nat_data      <= r.nat;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(table_response(r));
  endtask

  // Stops offering items and waits for all results, then lets the table settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_LIFETIME) lifetime = value;
    else interval = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic conn_req_t blank_req(op_t op);
    conn_req_t r;
    r = '{op, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
          $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
          {$urandom, $urandom}};
    return r;
  endfunction

  function automatic conn_req_t reversed(conn_req_t r);
    conn_req_t q;
    q     = r;
    q.sip = r.dip;
    q.dip = r.sip;
    q.sp  = r.dp;
    q.dp  = r.sp;
    return q;
  endfunction

  // Fresh tuple, optionally steered into a given set
  function automatic conn_req_t fresh_tuple(op_t op, int target);
    conn_req_t r;
    int        h;
    r = blank_req(op);
    if (target >= 0) begin
      h = set_index(r.sip, r.dip, r.sp, r.dp, r.pr);
      r.dp[7:0] = r.dp[7:0] ^ 8'(h) ^ 8'(target);
    end
    return r;
  endfunction

  function automatic conn_req_t with_key(op_t op, conn_req_t key);
    conn_req_t r;
    r     = blank_req(op);
    r.sip = key.sip;
    r.dip = key.dip;
    r.sp  = key.sp;
    r.dp  = key.dp;
    r.pr  = key.pr;
    return r;
  endfunction

  // Rule built around a known tuple so that it tends to hit
  function automatic conn_req_t rule_near(conn_req_t key);
    conn_req_t r;
    int        span;
    r = with_key(OP_DEL_RULE, key);
    r.smask = ~(32'hFFFF_FFFF >> $urandom_range(32));
    r.dmask = ~(32'hFFFF_FFFF >> $urandom_range(32));
    span    = $urandom_range(4096);
    r.sp    = (int'(key.sp) > span) ? key.sp - 16'(span) : 16'd0;
    r.sph   = (int'(key.sp) + span < 65536) ? key.sp + 16'(span) : 16'hFFFF;
    r.dp    = (int'(key.dp) > span) ? key.dp - 16'(span) : 16'd0;
    r.dph   = (int'(key.dp) + span < 65536) ? key.dp + 16'(span) : 16'hFFFF;
    if ($urandom_range(1)) r.pr = 8'd0;
    if ($urandom_range(9) == 0) r.sph = r.sp - 16'd1;
    return r;
  endfunction

  // Random item, mostly on known connections
  function automatic conn_req_t random_item();
    conn_req_t r;
    conn_req_t key;
    int        pick;
    int        target;
    op_t       op;
    pick = $urandom_range(99);
    if (pick < 25)      op = OP_ADD;
    else if (pick < 44) op = OP_FIND;
    else if (pick < 58) op = OP_NAT_QUERY;
    else if (pick < 63) op = OP_NAT_FAIL;
    else if (pick < 73) op = OP_NAT_OK;
    else if (pick < 83) op = OP_DEL_KEY;
    else if (pick < 87) op = OP_DEL_RULE;
    else                op = OP_TICK;
    if (op == OP_TICK) return blank_req(op);
    if (known_q.size() == 0 || (op == OP_ADD && $urandom_range(99) < 60) ||
        $urandom_range(99) < 8) begin
      target = ($urandom_range(99) < 40) ? hot_set[$urandom_range(3)] : -1;
      r = fresh_tuple(op, target);
      if (op == OP_ADD) begin
        known_q.push_back(r);
        if (known_q.size() > 160) void'(known_q.pop_front());
      end
      if (op == OP_DEL_RULE && $urandom_range(3) != 0) begin
        r.sph = 16'hFFFF;
        r.dph = 16'hFFFF;
      end
      return r;
    end
    key = known_q[$urandom_range(known_q.size() - 1)];
    if ($urandom_range(1)) key = reversed(key);
    if (op == OP_DEL_RULE) return rule_near(key);
    return with_key(op, key);
  endfunction

  task automatic run_random(int count);
    repeat (count) send_item(random_item());
  endtask

  // Every keyed operation on one connection, both directions
  task automatic test_keyed_ops();
    conn_req_t t;
    conn_req_t r;
    t = fresh_tuple(OP_FIND, -1);
    send_item(t);
    t.op = OP_ADD;
    send_item(t);
    send_item(reversed(t));
    send_item(with_key(OP_FIND, reversed(t)));
    send_item(with_key(OP_NAT_QUERY, t));
    send_item(with_key(OP_NAT_FAIL, t));
    send_item(with_key(OP_NAT_QUERY, reversed(t)));
    r = with_key(OP_NAT_OK, reversed(t));
    r.nat = 64'hFFFF_FFFF_FFFF_FFFF;
    send_item(r);
    send_item(with_key(OP_NAT_QUERY, t));
    send_item(with_key(OP_NAT_QUERY, reversed(t)));
    r = with_key(OP_NAT_OK, t);
    r.nat = 64'd0;
    send_item(r);
    send_item(with_key(OP_NAT_QUERY, t));
    send_item(with_key(OP_DEL_KEY, reversed(t)));
    send_item(with_key(OP_FIND, t));
    send_item(with_key(OP_NAT_QUERY, t));
    send_item(with_key(OP_NAT_FAIL, t));
    send_item(with_key(OP_NAT_OK, t));
    send_item(with_key(OP_DEL_KEY, t));
  endtask

  // All-ones and all-zero tuples, then a rule with an empty port range and a rule that matches everything
  task automatic test_extremes();
    conn_req_t r;
    r = '{OP_ADD, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1};
    send_item(r);
    r = '{OP_ADD, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
    send_item(r);
    r.op = OP_FIND;
    send_item(r);
    r.op  = OP_DEL_RULE;
    r.sph = 16'h0000;
    r.dph = 16'hFFFF;
    r.sp  = 16'h0001;
    send_item(r);
    r.sp  = 16'h0000;
    r.sph = 16'hFFFF;
    send_item(r);
  endtask

  // Five adds into one set: the last finds it full
  task automatic test_full_set();
    conn_req_t r;
    for (int k = 0; k <= NWAYS; k++) begin
      r = fresh_tuple(OP_ADD, hot_set[0]);
      send_item(r);
      known_q.push_back(r);
    end
    r = known_q[1];
    r.op = OP_DEL_KEY;
    send_item(r);
    r = fresh_tuple(OP_ADD, hot_set[0]);
    send_item(r);
    known_q.push_back(r);
  endtask

  // Ageing at the register extremes, find refreshing age
  task automatic test_ageing();
    conn_req_t t;
    write_reg(CFG_LIFETIME, 8'd1);
    write_reg(CFG_INTERVAL, 8'd1);
    t = fresh_tuple(OP_ADD, -1);
    send_item(t);
    send_item(blank_req(OP_TICK));
    send_item(with_key(OP_FIND, t));
    write_reg(CFG_LIFETIME, 8'd3);
    write_reg(CFG_INTERVAL, 8'd2);
    send_item(t);
    repeat (2) send_item(blank_req(OP_TICK));
    send_item(with_key(OP_FIND, reversed(t)));
    repeat (4) send_item(blank_req(OP_TICK));
    write_reg(CFG_LIFETIME, 8'd255);
    write_reg(CFG_INTERVAL, 8'd255);
    send_item(t);
    repeat (6) send_item(blank_req(OP_TICK));
    send_item(with_key(OP_FIND, t));
  endtask

  // Long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 400;
    run_random(30);
    drain();
  endtask

  // Random phases under different idling and register settings
  task automatic test_random_phases();
    int idle_set[4] = '{0, 80, 0, 27};
    int stall_set[4] = '{0, 0, 80, 27};
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(CFG_LIFETIME, 8'($urandom_range(4, 20)));
          write_reg(CFG_INTERVAL, 8'($urandom_range(2, 10)));
        end
        1: begin
          write_reg(CFG_LIFETIME, 8'd1);
          write_reg(CFG_INTERVAL, 8'd1);
        end
        2: begin
          write_reg(CFG_LIFETIME, 8'd255);
          write_reg(CFG_INTERVAL, 8'd255);
        end
        default: begin
          write_reg(CFG_LIFETIME, 8'($urandom_range(1, 255)));
          write_reg(CFG_INTERVAL, 8'($urandom_range(1, 12)));
        end
      endcase
      tx_idle_pct  = idle_set[ph % 4];
      rx_stall_pct = stall_set[ph % 4];
      run_random(120);
    end
    // Sender waits for every result before going on
    drain();
    tx_idle_pct  = 27;
    rx_stall_pct = 27;
    run_random(40);
  endtask

  // Sequence of tests
  initial begin
    errors       = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_cycles  = 0;
    lifetime     = 8'd7;
    interval     = 8'd5;
    now_secs     = 16'd0;
    sweep_cnt    = 8'd0;
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
    foreach (hot_set[k]) hot_set[k] = $urandom_range(NSETS - 1);
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_LIFETIME;
    cfg_data            <= 8'd0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_FIND;
    in_ch.src_ip        <= '0;
    in_ch.dst_ip        <= '0;
    in_ch.src_port      <= '0;
    in_ch.dst_port      <= '0;
    in_ch.protocol      <= '0;
    in_ch.src_mask      <= '0;
    in_ch.dst_mask      <= '0;
    in_ch.src_port_high <= '0;
    in_ch.dst_port_high <= '0;
    in_ch.state_handle  <= '0;
    in_ch.nat_data      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keyed_ops();
    test_extremes();
    test_full_set();
    test_ageing();
    test_backpressure();
    test_random_phases();

    drain();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/cct_pkg.sv
rtl/core/cct_if.sv
rtl/core/cct_row_ram.sv
rtl/core/cct_engine.sv
rtl/core/connection_tracking_table.sv
tb/sv/testbench.sv
